>>> rtl/core/pixel_point_operation_unit_core_macros.svh
// assertion macros used by the checker file
`ifndef PIXEL_POINT_OPERATION_UNIT_CORE_MACROS_SVH
`define PIXEL_POINT_OPERATION_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define PPOU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppou assertion failed");

// next-cycle implication
`define PPOU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppou assertion failed");

`endif

>>> rtl/core/ppou_pkg.sv
// shared types and codes of the pixel point operation unit
package ppou_pkg;

    localparam logic [2:0] MODE_BRIGHT    = 3'd0;
    localparam logic [2:0] MODE_CONTRAST  = 3'd1;
    localparam logic [2:0] MODE_INVERT    = 3'd2;
    localparam logic [2:0] MODE_THRESHOLD = 3'd3;
    localparam logic [2:0] MODE_KEY       = 3'd4;

    localparam logic [2:0] REG_MODE      = 3'd0;
    localparam logic [2:0] REG_SINGLE    = 3'd1;
    localparam logic [2:0] REG_BRIGHT    = 3'd2;
    localparam logic [2:0] REG_CONTRAST  = 3'd3;
    localparam logic [2:0] REG_THRESH    = 3'd4;
    localparam logic [2:0] REG_HUE_WIN   = 3'd5;
    localparam logic [2:0] REG_SB_WIN    = 3'd6;
    localparam logic [2:0] REG_KEY_GAINS = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic        single_channel;
        logic [8:0]  brightness_offset;
        logic [9:0]  contrast_gain;
        logic [23:0] channel_thresholds;
        logic [17:0] hue_window;
        logic [31:0] sat_bright_window;
        logic [29:0] key_gains;
    } t_cfg;

    typedef struct packed {
        logic hue_ok;
        logic sat_ok;
        logic bri_ok;
    } t_key_flags;

endpackage

>>> rtl/core/pixel_point_operation_unit_core.sv
// Pixel point operation unit: brightness, contrast, invert, threshold, hsb key.
// Input channel: i_in_valid with o_in_stall carries one rgb pixel per beat.
// Output channel: o_out_valid with i_out_stall carries one result pixel per beat.
// Config channel: i_cfg_valid/o_cfg_ready with register index and data;
// ready is always high. Write registers only while the pipe is empty.
// Three lanes, one per color channel, run the point operations in parallel
// beside a shared hsb unit that derives the key window hits; the output
// register merges lane results and zeroes green/blue for grey pixels.
// An accepted beat passes the first and second stage registers to the output register.
// Throughput is 1 pixel per cycle while the receiver does not stall; each of the
// three pipeline registers moves on when it is empty or the one after it moves.
// When the receiver stalls, the output beat holds and the stages behind it
// fill; the input stalls only once all three stages are full.
// Reset (i_rst_n low, synchronous) empties the pipe and restores the
// register defaults (contrast gain of one, all others zero).
module pixel_point_operation_unit_core
    import ppou_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_key_flags flags;
    logic       r_v1, r_v2, r_vo;
    logic       en0, en1, en2;
    logic [7:0] ch_g, ch_b;
    logic [7:0] res0, res1, res2;
    logic [7:0] r_red, r_green, r_blue;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg               <= '0;
            r_cfg.contrast_gain <= 10'(1 << GAIN_FRAC_BITS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE:      r_cfg.mode               <= i_cfg_data[2:0];
                REG_SINGLE:    r_cfg.single_channel     <= i_cfg_data[0];
                REG_BRIGHT:    r_cfg.brightness_offset  <= i_cfg_data[8:0];
                REG_CONTRAST:  r_cfg.contrast_gain      <= i_cfg_data[9:0];
                REG_THRESH:    r_cfg.channel_thresholds <= i_cfg_data[23:0];
                REG_HUE_WIN:   r_cfg.hue_window         <= i_cfg_data[17:0];
                REG_SB_WIN:    r_cfg.sat_bright_window  <= i_cfg_data;
                REG_KEY_GAINS: r_cfg.key_gains          <= i_cfg_data[29:0];
                default:       r_cfg                    <= r_cfg;
            endcase
        end
    end

    assign en2 = !r_vo || !i_out_stall;
    assign en1 = !r_v2 || en2;
    assign en0 = !r_v1 || en1;
    assign o_in_stall = !en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en0) r_v1 <= i_in_valid;
            if (en1) r_v2 <= r_v1;
            if (en2) r_vo <= r_v2;
        end
    end

    // grey pixels feed channel zero to every lane
    assign ch_g = r_cfg.single_channel ? i_red_in : i_green_in;
    assign ch_b = r_cfg.single_channel ? i_red_in : i_blue_in;

    ppou_hsb u_hsb (
        .i_clk   (i_clk),
        .i_en1   (en0),
        .i_en2   (en1),
        .i_r     (i_red_in),
        .i_g     (ch_g),
        .i_b     (ch_b),
        .i_cfg   (r_cfg),
        .o_flags (flags)
    );

    ppou_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_r (
        .i_clk (i_clk), .i_en1 (en0), .i_en2 (en1), .i_ch (i_red_in),
        .i_thr (r_cfg.channel_thresholds[23:16]), .i_cfg (r_cfg),
        .i_flags (flags), .o_res (res0)
    );

    ppou_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_g (
        .i_clk (i_clk), .i_en1 (en0), .i_en2 (en1), .i_ch (ch_g),
        .i_thr (r_cfg.channel_thresholds[15:8]), .i_cfg (r_cfg),
        .i_flags (flags), .o_res (res1)
    );

    ppou_lane #(.GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_lane_b (
        .i_clk (i_clk), .i_en1 (en0), .i_en2 (en1), .i_ch (ch_b),
        .i_thr (r_cfg.channel_thresholds[7:0]), .i_cfg (r_cfg),
        .i_flags (flags), .o_res (res2)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_red   <= res0;
            r_green <= r_cfg.single_channel ? 8'd0 : res1;
            r_blue  <= r_cfg.single_channel ? 8'd0 : res2;
        end
    end

    assign o_out_valid = r_vo;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

endmodule

>>> rtl/core/ppou_hsb.sv
// hsb conversion and window tests, two pipeline stages
module ppou_hsb
    import ppou_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_en1,
    input  logic       i_en2,
    input  logic [7:0] i_r,
    input  logic [7:0] i_g,
    input  logic [7:0] i_b,
    input  t_cfg       i_cfg,
    output t_key_flags o_flags
);

    logic [7:0]  v, m, d;
    logic [11:0] n_full;
    logic [10:0] n_n;
    logic [7:0]  n_dd, n_sd, n_sm;

    logic [10:0] r_n;
    logic [7:0]  r_dd, r_sd, r_sm, r_v;
    t_key_flags  r_flags;

    logic [19:0] hn, hl, hu;
    logic [15:0] s_num, s_max, s_min;
    logic [8:0]  lo, hi;
    t_key_flags  n_flags;

    always_comb begin
        v = i_r;
        m = i_r;
        if (i_g > v) v = i_g;
        if (i_b > v) v = i_b;
        if (i_g < m) m = i_g;
        if (i_b < m) m = i_b;
        d = v - m;
        n_full = '0;
        if (i_r == v) begin
            if (i_g >= i_b) n_full = {4'd0, i_g} - {4'd0, i_b};
            else n_full = 12'd6 * {4'd0, d} - ({4'd0, i_b} - {4'd0, i_g});
        end else if (i_g == v) begin
            n_full = 12'd2 * {4'd0, d} + {4'd0, i_b} - {4'd0, i_r};
        end else begin
            n_full = 12'd4 * {4'd0, d} + {4'd0, i_r} - {4'd0, i_g};
        end
        if (d == 8'd0) begin
            n_n  = '0;
            n_dd = 8'd1;
            n_sd = 8'd0;
            n_sm = 8'd1;
        end else begin
            n_n  = n_full[10:0];
            n_dd = d;
            n_sd = d;
            n_sm = v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_n  <= n_n;
            r_dd <= n_dd;
            r_sd <= n_sd;
            r_sm <= n_sm;
            r_v  <= v;
        end
    end

    // hue compared by cross multiplication against 6*d*bound
    always_comb begin
        lo    = i_cfg.hue_window[8:0];
        hi    = i_cfg.hue_window[17:9];
        hn    = 20'd255 * {9'd0, r_n};
        hl    = 20'd6 * ({12'd0, r_dd} * {11'd0, lo});
        hu    = 20'd6 * ({12'd0, r_dd} * {11'd0, hi});
        s_num = 16'd255 * {8'd0, r_sd};
        s_max = {8'd0, i_cfg.sat_bright_window[31:24]} * {8'd0, r_sm};
        s_min = {8'd0, i_cfg.sat_bright_window[23:16]} * {8'd0, r_sm};
        if (lo < hi) n_flags.hue_ok = (hn > hl) && (hn < hu);
        else if (lo > hi) n_flags.hue_ok = (hn > hl) || (hn < hu);
        else n_flags.hue_ok = 1'b0;
        n_flags.sat_ok = (s_num < s_max) && (s_num > s_min);
        n_flags.bri_ok = (r_v < i_cfg.sat_bright_window[15:8])
                      && (r_v > i_cfg.sat_bright_window[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) r_flags <= n_flags;
    end

    assign o_flags = r_flags;

endmodule

>>> rtl/core/ppou_lane.sv
// one channel lane: point operations and key gain terms
module ppou_lane
    import ppou_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_en1,
    input  logic       i_en2,
    input  logic [7:0] i_ch,
    input  logic [7:0] i_thr,
    input  t_cfg       i_cfg,
    input  t_key_flags i_flags,
    output logic [7:0] o_res
);

    localparam int PW = 19;

    function automatic logic signed [PW-1:0] trunc_q(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        mag = p[PW-1] ? -p : p;
        mag = mag >> GAIN_FRAC_BITS;
        return p[PW-1] ? -$signed(mag) : $signed(mag);
    endfunction

    logic signed [9:0]    gh, gs, gb;
    logic signed [PW-1:0] n_th, n_ts, n_tb;
    logic [17:0]          n_con;

    logic [7:0]           r_ch;
    logic [17:0]          r_con;
    logic signed [PW-1:0] r_th, r_ts, r_tb;

    logic [7:0]           r_base;
    logic signed [PW-1:0] r_th2, r_ts2, r_tb2;

    logic [7:0]           n_base;
    logic signed [10:0]   bsum;
    logic [17:0]          con_sh;
    logic signed [PW+1:0] ksum;

    always_comb begin
        gh    = i_cfg.key_gains[29:20];
        gs    = i_cfg.key_gains[19:10];
        gb    = i_cfg.key_gains[9:0];
        n_con = {10'd0, i_ch} * {8'd0, i_cfg.contrast_gain};
        n_th  = trunc_q(PW'(gh) * $signed({11'd0, i_ch}));
        n_ts  = trunc_q(PW'(gs) * $signed({11'd0, i_ch}));
        n_tb  = trunc_q(PW'(gb) * $signed(PW'(255)));
    end

    always_ff @(posedge i_clk) begin
        if (i_en1) begin
            r_ch  <= i_ch;
            r_con <= n_con;
            r_th  <= n_th;
            r_ts  <= n_ts;
            r_tb  <= n_tb;
        end
    end

    always_comb begin
        bsum   = $signed({3'd0, r_ch}) + 11'(signed'(i_cfg.brightness_offset));
        con_sh = r_con >> GAIN_FRAC_BITS;
        case (i_cfg.mode)
            MODE_BRIGHT: begin
                if (bsum < 0) n_base = 8'd0;
                else if (bsum > 11'sd255) n_base = 8'd255;
                else n_base = bsum[7:0];
            end
            MODE_CONTRAST:  n_base = (con_sh > 18'd255) ? 8'd255 : con_sh[7:0];
            MODE_INVERT:    n_base = 8'd255 - r_ch;
            MODE_THRESHOLD: n_base = (r_ch > i_thr) ? r_ch : 8'd0;
            default:        n_base = r_ch;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_base <= n_base;
            r_th2  <= r_th;
            r_ts2  <= r_ts;
            r_tb2  <= r_tb;
        end
    end

    always_comb begin
        ksum = '0;
        if (i_flags.hue_ok) ksum = ksum + (PW+2)'(r_th2);
        if (i_flags.sat_ok) ksum = ksum + (PW+2)'(r_ts2);
        if (i_flags.bri_ok) ksum = ksum + (PW+2)'(r_tb2);
        if (i_cfg.mode == MODE_KEY) begin
            if (ksum < 0) o_res = 8'd0;
            else if (ksum > 255) o_res = 8'd255;
            else o_res = ksum[7:0];
        end else begin
            o_res = r_base;
        end
    end

endmodule

>>> rtl/core/ppou_chk.sv
// port checker for the pixel point operation unit and its bind
`include "pixel_point_operation_unit_core_macros.svh"

module ppou_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_red_out,
    input logic [7:0] o_green_out,
    input logic [7:0] o_blue_out,
    input logic       o_cfg_ready
);

    `PPOU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_red_out) && $stable(o_green_out) && $stable(o_blue_out))

    // input only backs up when every stage is full behind a stalled beat
    `PPOU_ASSERT_IMPL(a_in_stall_cause, i_clk, i_rst_n, o_in_stall,
        o_out_valid && i_out_stall)

    // an accepted beat reaches the output through a free-running pipe
    `PPOU_ASSERT_NEXT(a_latency, i_clk, i_rst_n,
        i_in_valid && !o_in_stall ##1 !i_out_stall ##1 !i_out_stall, o_out_valid)

    `PPOU_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready)

endmodule

bind pixel_point_operation_unit_core ppou_chk u_ppou_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_cfg_ready (o_cfg_ready)
);
